### design/uart_baud_divisor_search_top_defines.svh
// assertion macros used by the checker file
`ifndef UART_BAUD_DIVISOR_SEARCH_TOP_DEFINES_SVH
`define UART_BAUD_DIVISOR_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UBDS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UBDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ubds_pkg.sv
// shared types and constants of the baud divisor search
package ubds_pkg;

    localparam int unsigned BAUD_W    = 24;
    localparam int unsigned CLOCK_W   = 26;
    localparam int unsigned DVS_W     = 32;
    localparam int unsigned CODE_W    = 5;
    localparam int unsigned DIV_W     = 13;
    localparam int unsigned ERR_W     = 32;
    localparam int unsigned S_DATA_W  = 24;
    localparam int unsigned M_DATA_W  = 56;
    localparam int unsigned DIV_STAGES = CLOCK_W;

    localparam logic [CODE_W-1:0]  MAX_CODE    = 5'd31;
    localparam logic [CODE_W-1:0]  MIN_CODE    = 5'd3;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 26'd20971520;
    localparam logic [ERR_W-1:0]   ERR_NONE    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        TAG_BASE  = 2'd0,
        TAG_LOWER = 2'd1,
        TAG_UPPER = 2'd2
    } div_tag_t;

    typedef struct packed {
        logic               valid;
        div_tag_t           tag;
        logic [CLOCK_W-1:0] rem;
        logic [CLOCK_W-1:0] word;
        logic [DVS_W-1:0]   dvs;
    } div_lane_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD1,
        ST_ISSUE1,
        ST_WAIT1,
        ST_PROD2,
        ST_ISSUE2,
        ST_ISSUE3,
        ST_WAIT2,
        ST_OUT
    } search_state_t;

endpackage

### design/uart_baud_divisor_search_top.sv
// baud divisor search: sequencer, trial compare and stream ports
// Each item (a requested baud rate) runs a search over oversampling codes 31
// down to 3, three divisions per code on a 26-cell pipelined divider row.
// The base quotient must return before the two trial divisions can go in; a
// zero baud rate skips the search and goes straight to the output state. A
// result stalled in the output register holds the block in its output state,
// once the next search is done, until it is taken. One item is searched at a
// time; its result sits in an output register while the next item is
// accepted. clock_hz is written through cfg_valid/cfg_data; the user must
// write it only while the block idles, as the block itself does not enforce this.
module uart_baud_divisor_search_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ubds_pkg::CLOCK_W-1:0]   cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [23:0] baud_rate
    input  logic [ubds_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [4:0] divisor_high, [12:5] divisor_low, [17:13] oversample_code,
    // [49:18] best_error, [50] found, [55:51] zero
    output logic [ubds_pkg::M_DATA_W-1:0]  m_tdata
);
    import ubds_pkg::*;

    search_state_t       state_reg, state_next;
    logic [CLOCK_W-1:0]  clock_reg;
    logic [BAUD_W-1:0]   baud_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [DVS_W-1:0]    prod_a_reg, prod_b_reg, prod_c_reg;
    logic [CLOCK_W-1:0]  d_reg;
    logic [ERR_W-1:0]    best_reg;
    logic                found_reg;
    logic [DIV_W-1:0]    held_div_reg;
    logic [CODE_W-1:0]   held_os_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    div_lane_t           head, tail;
    logic                out_load;
    logic [CODE_W:0]     ratio;
    logic [CLOCK_W:0]    d_plus;
    logic [ERR_W-1:0]    err_lo, err_hi;
    logic                win_lo, win_hi;
    logic                s_accept;
    logic [DVS_W-1:0]    ratio_wide;
    logic [DVS_W-1:0]    mul_a;
    logic [DVS_W-1:0]    mul_b;
    logic [DVS_W-1:0]    mul_c;

    assign cfg_ready  = 1'b1;
    assign s_accept   = s_tvalid && s_tready;
    assign ratio      = {1'b0, code_reg} + 6'd1;
    assign d_plus     = {1'b0, d_reg} + 27'd1;
    assign ratio_wide = {{(DVS_W-CODE_W-1){1'b0}}, ratio};
    assign mul_a      = {{(DVS_W-BAUD_W){1'b0}}, baud_reg} * ratio_wide;
    assign mul_b      = {{(DVS_W-CLOCK_W){1'b0}}, d_reg} * ratio_wide;
    assign mul_c      = {{(DVS_W-CLOCK_W-1){1'b0}}, d_plus} * ratio_wide;

    // trial errors wrap at 32 bits
    assign err_lo = {{(ERR_W-CLOCK_W){1'b0}}, tail.word} - {{(ERR_W-BAUD_W){1'b0}}, baud_reg};
    assign err_hi = {{(ERR_W-BAUD_W){1'b0}}, baud_reg} - {{(ERR_W-CLOCK_W){1'b0}}, tail.word};
    assign win_lo = tail.valid && tail.tag == TAG_LOWER && err_lo < best_reg
                    && d_reg[CLOCK_W-1:DIV_W] == '0;
    assign win_hi = tail.valid && tail.tag == TAG_UPPER && err_hi < best_reg
                    && d_plus[CLOCK_W:DIV_W] == '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tdata == '0) ? ST_OUT : ST_PROD1;
                end
            end
            ST_PROD1:  state_next = ST_ISSUE1;
            ST_ISSUE1: state_next = ST_WAIT1;
            ST_WAIT1: begin
                if (tail.valid && tail.tag == TAG_BASE) begin
                    state_next = ST_PROD2;
                end
            end
            ST_PROD2:  state_next = ST_ISSUE2;
            ST_ISSUE2: state_next = ST_ISSUE3;
            ST_ISSUE3: state_next = ST_WAIT2;
            ST_WAIT2: begin
                if (tail.valid && tail.tag == TAG_UPPER) begin
                    state_next = (code_reg == MIN_CODE) ? ST_OUT : ST_PROD1;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready   = 1'b0;
        out_load   = 1'b0;
        head.valid = 1'b0;
        head.tag   = TAG_BASE;
        head.rem   = '0;
        head.word  = clock_reg;
        head.dvs   = prod_a_reg;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_ISSUE1: head.valid = 1'b1;
            ST_ISSUE2: begin
                head.valid = 1'b1;
                head.tag   = TAG_LOWER;
                head.dvs   = prod_b_reg;
            end
            ST_ISSUE3: begin
                head.valid = 1'b1;
                head.tag   = TAG_UPPER;
                head.dvs   = prod_c_reg;
            end
            ST_OUT:    out_load = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    ubds_div_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .tail    (tail)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clock_reg    <= CLOCK_RESET;
            held_div_reg <= '0;
            held_os_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            best_reg     <= ERR_NONE;
            found_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                clock_reg <= cfg_data;
            end
            if (s_accept) begin
                best_reg  <= ERR_NONE;
                found_reg <= 1'b0;
            end else if (win_lo) begin
                best_reg     <= err_lo;
                found_reg    <= 1'b1;
                held_div_reg <= d_reg[DIV_W-1:0];
                held_os_reg  <= code_reg;
            end else if (win_hi) begin
                best_reg     <= err_hi;
                found_reg    <= 1'b1;
                held_div_reg <= d_plus[DIV_W-1:0];
                held_os_reg  <= code_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            baud_reg <= s_tdata;
            code_reg <= MAX_CODE;
        end else if (state_reg == ST_WAIT2 && state_next == ST_PROD1) begin
            code_reg <= code_reg - 5'd1;
        end
        if (state_reg == ST_PROD1) begin
            prod_a_reg <= mul_a;
        end
        // a zero quotient is raised to one
        if (state_reg == ST_WAIT1 && tail.valid && tail.tag == TAG_BASE) begin
            d_reg <= (tail.word == '0) ? {{(CLOCK_W-1){1'b0}}, 1'b1} : tail.word;
        end
        if (state_reg == ST_PROD2) begin
            prod_b_reg <= mul_b;
            prod_c_reg <= mul_c;
        end
        if (out_load) begin
            m_tdata_reg <= {5'd0, found_reg, best_reg, held_os_reg,
                            held_div_reg[7:0], held_div_reg[12:8]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### design/ubds_div_cell.sv
// one restoring-division cell: resolves one quotient bit per item
module ubds_div_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ubds_pkg::div_lane_t   lane_in,
    output ubds_pkg::div_lane_t   lane_out
);
    import ubds_pkg::*;

    div_lane_t          lane_reg;
    div_lane_t          lane_next;
    logic [CLOCK_W:0]   rem_shift;
    logic               take;
    logic [CLOCK_W:0]   rem_sub;

    always_comb begin
        rem_shift = {lane_in.rem, lane_in.word[CLOCK_W-1]};
        take      = {{(DVS_W-CLOCK_W-1){1'b0}}, rem_shift} >= lane_in.dvs;
        rem_sub   = rem_shift - lane_in.dvs[CLOCK_W:0];
        lane_next       = lane_in;
        lane_next.rem   = take ? rem_sub[CLOCK_W-1:0] : rem_shift[CLOCK_W-1:0];
        lane_next.word  = {lane_in.word[CLOCK_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else begin
            lane_reg.valid <= lane_next.valid;
        end
        lane_reg.tag  <= lane_next.tag;
        lane_reg.rem  <= lane_next.rem;
        lane_reg.word <= lane_next.word;
        lane_reg.dvs  <= lane_next.dvs;
    end

    assign lane_out = lane_reg;

endmodule

### design/ubds_div_chain.sv
// row of division cells, one quotient bit per cell, a new division may enter each cycle
module ubds_div_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ubds_pkg::div_lane_t   head,
    output ubds_pkg::div_lane_t   tail
);
    import ubds_pkg::*;

    div_lane_t lane [DIV_STAGES+1];

    assign lane[0] = head;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_cell
        ubds_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    assign tail = lane[DIV_STAGES];

endmodule

### design/ubds_checker.sv
// port-level checks of the baud divisor search, bound to the top level
`include "uart_baud_divisor_search_top_defines.svh"

module ubds_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ubds_pkg::M_DATA_W-1:0]  m_tdata
);
    import ubds_pkg::*;

    `UBDS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result item changed while stalled")

    `UBDS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "second item taken during a search")

    `UBDS_ASSERT_NOW(a_none_full_err, aclk, aresetn, m_tvalid && !m_tdata[50],
        m_tdata[49:18] == ERR_NONE, "no trial found but error is not all ones")

    `UBDS_ASSERT_NOW(a_found_nonzero, aclk, aresetn, m_tvalid && m_tdata[50],
        m_tdata[12:0] != 13'd0, "found flag with a zero divisor")

endmodule

bind uart_baud_divisor_search_top ubds_checker u_ubds_checker (.*);

### tb/tb.sv
// testbench for the baud divisor search: directed and random baud rates over several clocks
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ubds_pkg::*;

    typedef struct packed {
        logic [4:0]  div_high;
        logic [7:0]  div_low;
        logic [4:0]  code;
        logic [31:0] best_err;
        logic        found;
    } search_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CLOCK_W-1:0]  cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state
    logic [31:0]    clock_hz_now = 32'(CLOCK_RESET);
    logic [12:0]    held_div = '0;
    logic [4:0]     held_code = '0;
    search_result_t pending_results[$];
    int             mismatches = 0;
    bit             calm = 1'b0;

    uart_baud_divisor_search_top dut (.*);

    always #6 aclk = ~aclk;

    // result side stalls at random unless calm
    always @(negedge aclk)
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);

    function automatic search_result_t search_baud(input logic [23:0] baud);
        search_result_t r;
        logic [31:0] best, ratio, d, err;
        logic        hit;
        best = ERR_NONE;
        hit = 1'b0;
        if (baud != 0) begin
            for (int c = 31; c >= 3; c--) begin
                ratio = 32'(c + 1);
                d = clock_hz_now / (32'(baud) * ratio);
                if (d == 0) d = 1;
                err = clock_hz_now / (d * ratio) - 32'(baud);
                if (err < best && d <= 8191) begin
                    best = err; held_div = d[12:0]; held_code = 5'(c); hit = 1'b1;
                end
                d = d + 1;
                err = 32'(baud) - clock_hz_now / (d * ratio);
                if (err < best && d <= 8191) begin
                    best = err; held_div = d[12:0]; held_code = 5'(c); hit = 1'b1;
                end
            end
        end
        r.div_high = held_div[12:8];
        r.div_low = held_div[7:0];
        r.code = held_code;
        r.best_err = best;
        r.found = hit;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            search_result_t want, got;
            got.div_high = m_tdata[4:0];
            got.div_low = m_tdata[12:5];
            got.code = m_tdata[17:13];
            got.best_err = m_tdata[49:18];
            got.found = m_tdata[50];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[55:51] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp hi=%0d lo=%0d code=%0d err=%h found=%b,",
                                  " got hi=%0d lo=%0d code=%0d err=%h found=%b"},
                                 want.div_high, want.div_low, want.code, want.best_err,
                                 want.found, got.div_high, got.div_low, got.code,
                                 got.best_err, got.found);
                end
            end
        end
    end

    task automatic send_baud(input logic [23:0] baud);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 24) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= baud;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(search_baud(baud));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_clock(input logic [CLOCK_W-1:0] hz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= hz;
        do @(posedge aclk); while (!cfg_ready);
        clock_hz_now = 32'(hz);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_baud();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 16));
            2: return 24'($urandom_range(1, 4000));
            default: return 24'($urandom_range(300, 1000000));
        endcase
    endfunction

    task automatic test_directed_baud();
        logic [23:0] edge_bauds[12] = '{24'd9600, 24'd115200, 24'd1, 24'd0,
            24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'd300, 24'd921600,
            24'd2, 24'd1000000, 24'd57600};
        foreach (edge_bauds[i]) send_baud(edge_bauds[i]);
    endtask

    task automatic test_clock_extremes();
        write_clock(26'd1);
        send_baud(24'd1);
        send_baud(24'd9600);
        send_baud(24'hFFFFFF);
        write_clock(26'h3FFFFFF);
        send_baud(24'd1);
        send_baud(24'd115200);
        send_baud(24'hFFFFFF);
        send_baud(24'd0);
    endtask

    task automatic test_random_baud();
        logic [CLOCK_W-1:0] clocks[4] = '{26'd20971520, 26'd48000000, 26'd1843200,
                                          26'h3FFFFFF};
        calm = 1'b1;
        for (int i = 0; i < 270; i++) begin
            if (i == 40) calm = 1'b0;
            if (i % 45 == 44) begin
                if ($urandom_range(0, 2) == 0) write_clock(26'($urandom));
                else write_clock(clocks[$urandom_range(0, 3)]);
            end
            send_baud(pick_baud());
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_baud();
        test_clock_extremes();
        test_random_baud();
        drain();
        if (mismatches == 0 && pending_results.size() == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
